>>> design/h2r_pkg.sv
`default_nettype none

package h2r_pkg;

    localparam int FRAC_BITS = 16;
    localparam int HUE_W     = FRAC_BITS;
    localparam int FRAC_W    = FRAC_BITS + 1;
    localparam int POS_W     = FRAC_BITS + 2;
    localparam int TWICE_W   = POS_W + 1;
    localparam int SUM_W     = FRAC_BITS + 2;
    localparam int PROD_W    = 2 * FRAC_W;
    localparam int VAL_W     = 2 * FRAC_BITS + 1;
    localparam int CHAN_W    = 8;
    localparam int SCALE_W   = VAL_W + CHAN_W;
    localparam int TOP_W     = SCALE_W - 2 * FRAC_BITS;
    localparam int COLOR_W   = 3 * CHAN_W;
    localparam int NUM_CHAN  = 3;

    localparam int CH_RED    = 0;
    localparam int CH_GREEN  = 1;
    localparam int CH_BLUE   = 2;

    localparam int NUM_STAGES = 5;
    localparam int ST_MUL     = 0;
    localparam int ST_RAMP    = 1;
    localparam int ST_PROD    = 2;
    localparam int ST_SUM     = 3;
    localparam int ST_SCALE   = 4;

    localparam logic [FRAC_W-1:0]  ONE_F   = FRAC_W'(1) << FRAC_BITS;
    localparam logic [FRAC_W-1:0]  HALF_F  = FRAC_W'(1) << (FRAC_BITS - 1);
    localparam logic [POS_W-1:0]   ONE_P   = POS_W'(1) << FRAC_BITS;
    localparam logic [POS_W-1:0]   TWO_P   = POS_W'(2) << FRAC_BITS;
    localparam logic [POS_W-1:0]   THREE_P = POS_W'(3) << FRAC_BITS;
    localparam logic [TWICE_W-1:0] ONE_T   = TWICE_W'(1) << FRAC_BITS;
    localparam logic [TWICE_W-1:0] THREE_T = TWICE_W'(3) << FRAC_BITS;
    localparam logic [TWICE_W-1:0] FOUR_T  = TWICE_W'(4) << FRAC_BITS;
    localparam logic [TOP_W-1:0]   CHAN_MAX = TOP_W'(255);

    typedef struct packed {
        logic [NUM_STAGES-1:0] stage_en;
    } h2r_ctrl_t;

endpackage

`default_nettype wire

>>> design/h2r_stream_if.sv
`default_nettype none

interface h2r_hsl_if
    import h2r_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [HUE_W-1:0]  hue;
    logic [FRAC_W-1:0] saturation;
    logic [FRAC_W-1:0] lightness;

    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    output ready);
endinterface

interface h2r_rgb_if
    import h2r_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] packed_color;

    modport source (output valid, output packed_color, input ready);
    modport sink   (input valid, input packed_color, output ready);
endinterface

`default_nettype wire

>>> design/h2r_front.sv
`default_nettype none

module h2r_front
    import h2r_pkg::*;
(
    input  wire logic               clk,
    input  wire h2r_ctrl_t          ctrl,
    input  wire logic [HUE_W-1:0]   hue,
    input  wire logic [FRAC_W-1:0]  saturation,
    input  wire logic [FRAC_W-1:0]  lightness,
    output logic      [FRAC_W-1:0]  diff,
    output logic      [FRAC_W-1:0]  base  [NUM_CHAN],
    output logic      [FRAC_W-1:0]  slope [NUM_CHAN]
);

    logic [FRAC_W-1:0] sat_c;
    logic [FRAC_W-1:0] light_c;
    logic [POS_W-1:0]  h3;
    logic [POS_W-1:0]  pos_r;
    logic [POS_W-1:0]  pos_b;

    logic [FRAC_W-1:0] s_reg;
    logic [FRAC_W-1:0] l_reg;
    logic [PROD_W-1:0] ls_reg;
    logic [POS_W-1:0]  pos_reg [NUM_CHAN];

    logic [FRAC_W-1:0] m;
    logic [SUM_W-1:0]  q_full;
    logic [SUM_W-1:0]  p_full;
    logic [FRAC_W-1:0] q;
    logic [FRAC_W-1:0] p;
    logic [TWICE_W-1:0] t2 [NUM_CHAN];
    logic [TWICE_W-1:0] fall [NUM_CHAN];

    logic [FRAC_W-1:0] diff_next;
    logic [FRAC_W-1:0] base_next  [NUM_CHAN];
    logic [FRAC_W-1:0] slope_next [NUM_CHAN];
    logic [FRAC_W-1:0] diff_reg;
    logic [FRAC_W-1:0] base_reg  [NUM_CHAN];
    logic [FRAC_W-1:0] slope_reg [NUM_CHAN];

    always_comb
    begin
        sat_c   = (saturation > ONE_F) ? ONE_F : saturation;
        light_c = (lightness > ONE_F) ? ONE_F : lightness;
        h3      = POS_W'(hue) + {1'b0, hue, 1'b0};
        pos_r   = h3 + ONE_P;
        if (pos_r >= THREE_P)
        begin
            pos_r = pos_r - THREE_P;
        end
        pos_b   = (h3 >= ONE_P) ? (h3 - ONE_P) : (h3 + TWO_P);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.stage_en[ST_MUL])
        begin
            s_reg            <= sat_c;
            l_reg            <= light_c;
            ls_reg           <= PROD_W'(light_c) * PROD_W'(sat_c);
            pos_reg[CH_RED]   <= pos_r;
            pos_reg[CH_GREEN] <= h3;
            pos_reg[CH_BLUE]  <= pos_b;
        end
    end

    always_comb
    begin
        m = ls_reg[FRAC_BITS +: FRAC_W];
        if (l_reg < HALF_F)
        begin
            q_full = SUM_W'(l_reg) + SUM_W'(m);
        end
        else
        begin
            q_full = SUM_W'(l_reg) + SUM_W'(s_reg) - SUM_W'(m);
        end
        q         = q_full[FRAC_W-1:0];
        p_full    = {l_reg, 1'b0} - SUM_W'(q);
        p         = p_full[FRAC_W-1:0];
        diff_next = q - p;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            t2[c]   = {pos_reg[c], 1'b0};
            fall[c] = FOUR_T - t2[c];
            if (t2[c] < ONE_T)
            begin
                base_next[c]  = p;
                slope_next[c] = t2[c][FRAC_W-1:0];
            end
            else if (t2[c] < THREE_T)
            begin
                base_next[c]  = q;
                slope_next[c] = '0;
            end
            else if (t2[c] < FOUR_T)
            begin
                base_next[c]  = p;
                slope_next[c] = fall[c][FRAC_W-1:0];
            end
            else
            begin
                base_next[c]  = p;
                slope_next[c] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.stage_en[ST_RAMP])
        begin
            diff_reg <= diff_next;
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                base_reg[c]  <= base_next[c];
                slope_reg[c] <= slope_next[c];
            end
        end
    end

    assign diff  = diff_reg;
    assign base  = base_reg;
    assign slope = slope_reg;

endmodule

`default_nettype wire

>>> design/h2r_channel.sv
`default_nettype none

module h2r_channel
    import h2r_pkg::*;
(
    input  wire logic              clk,
    input  wire h2r_ctrl_t         ctrl,
    input  wire logic [FRAC_W-1:0] diff,
    input  wire logic [FRAC_W-1:0] base,
    input  wire logic [FRAC_W-1:0] slope,
    output logic      [CHAN_W-1:0] chan
);

    logic [PROD_W-1:0]  prod_reg;
    logic [FRAC_W-1:0]  base_reg;
    logic [VAL_W-1:0]   val_reg;
    logic [VAL_W-1:0]   val_next;
    logic [SCALE_W-1:0] scaled;
    logic [TOP_W-1:0]   top_bits;
    logic [CHAN_W-1:0]  chan_next;
    logic [CHAN_W-1:0]  chan_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.stage_en[ST_PROD])
        begin
            prod_reg <= PROD_W'(diff) * PROD_W'(slope);
            base_reg <= base;
        end
    end

    assign val_next = {base_reg, {FRAC_BITS{1'b0}}} + prod_reg[VAL_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.stage_en[ST_SUM])
        begin
            val_reg <= val_next;
        end
    end

    always_comb
    begin
        scaled    = {val_reg, {CHAN_W{1'b0}}} - SCALE_W'(val_reg);
        top_bits  = scaled[SCALE_W-1 -: TOP_W];
        chan_next = (top_bits > CHAN_MAX) ? CHAN_MAX[CHAN_W-1:0] : top_bits[CHAN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.stage_en[ST_SCALE])
        begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

`default_nettype wire

>>> design/hsl_to_rgb_converter.sv
`default_nettype none

// Channel  Role    Contents
// hsl      sink    hue[15:0], saturation[16:0], lightness[16:0]
// rgb      source  packed_color[23:0]: red 23:16, green 15:8, blue 7:0
//
// One transaction is accepted per clock unless a stalled output has backed the pipeline up to its input.
// The five register stages are the saturation product, the ramp selection,
// the per-channel slope product, the channel sum and the scale by 255.
// Reset clears only the stage valid bits; the block is empty after reset.
// A stalled output holds its stage, and each earlier stage advances whenever
// the stage after it has room, so bubbles close up while the output waits.

module hsl_to_rgb_converter
    import h2r_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    h2r_hsl_if.sink    hsl,
    h2r_rgb_if.source  rgb
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    h2r_ctrl_t             ctrl;

    logic [FRAC_W-1:0] diff;
    logic [FRAC_W-1:0] base  [NUM_CHAN];
    logic [FRAC_W-1:0] slope [NUM_CHAN];
    logic [CHAN_W-1:0] chan  [NUM_CHAN];

    always_comb
    begin
        ctrl.stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || rgb.ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            ctrl.stage_en[i] = !valid_reg[i] || ctrl.stage_en[i+1];
        end
        valid_next = valid_reg;
        if (ctrl.stage_en[0])
        begin
            valid_next[0] = hsl.valid;
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (ctrl.stage_en[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    h2r_front u_front (
        .clk        (clk),
        .ctrl       (ctrl),
        .hue        (hsl.hue),
        .saturation (hsl.saturation),
        .lightness  (hsl.lightness),
        .diff       (diff),
        .base       (base),
        .slope      (slope)
    );

    for (genvar c = 0; c < NUM_CHAN; c++)
    begin : g_chan
        h2r_channel u_channel (
            .clk   (clk),
            .ctrl  (ctrl),
            .diff  (diff),
            .base  (base[c]),
            .slope (slope[c]),
            .chan  (chan[c])
        );
    end

    assign hsl.ready        = ctrl.stage_en[ST_MUL];
    assign rgb.valid        = valid_reg[NUM_STAGES-1];
    assign rgb.packed_color = {chan[CH_RED], chan[CH_GREEN], chan[CH_BLUE]};

endmodule

`default_nettype wire

>>> tb/sv/tb_hsl_to_rgb_converter.sv
`default_nettype none

class rgb_expectations;
    logic [h2r_pkg::COLOR_W-1:0] pending_colors[$];
    int unsigned error_count;

    function new();
        error_count = 0;
    endfunction

    function bit [63:0] scale_channel(bit [63:0] num, int shift);
        bit [63:0] c;
        c = (num * 64'd255) >> shift;
        return (c > 64'd255) ? 64'd255 : c;
    endfunction

    // The position is in units of a third of ONE, so the sixth and half
    // boundaries of the ramp are compared exactly.
    function bit [63:0] ramp_value(bit [63:0] p, bit [63:0] q, bit [63:0] pos);
        bit [63:0] one;
        bit [63:0] d;
        one = 64'd1 << h2r_pkg::FRAC_BITS;
        d = q - p;
        if (64'd2 * pos < one)
            return p * one + d * (64'd2 * pos);
        if (64'd2 * pos < 64'd3 * one)
            return q * one;
        if (pos < 64'd2 * one)
            return p * one + d * (64'd4 * one - 64'd2 * pos);
        return p * one;
    endfunction

    function logic [h2r_pkg::COLOR_W-1:0] predict_color(
        logic [h2r_pkg::HUE_W-1:0]  hue,
        logic [h2r_pkg::FRAC_W-1:0] sat,
        logic [h2r_pkg::FRAC_W-1:0] light
    );
        bit [63:0] one;
        bit [63:0] h;
        bit [63:0] s;
        bit [63:0] l;
        bit [63:0] q;
        bit [63:0] p;
        bit [63:0] h3;
        bit [63:0] full3;
        bit [63:0] tr;
        bit [63:0] tb;
        bit [63:0] r;
        bit [63:0] g;
        bit [63:0] b;
        one = 64'd1 << h2r_pkg::FRAC_BITS;
        h = 64'(hue) & (one - 64'd1);
        s = 64'(sat);
        l = 64'(light);
        if (s > one)
            s = one;
        if (l > one)
            l = one;
        if (s == 64'd0)
        begin
            r = scale_channel(l, h2r_pkg::FRAC_BITS);
            g = r;
            b = r;
        end
        else
        begin
            full3 = 64'd3 * one;
            h3 = 64'd3 * h;
            if (l < (one >> 1))
                q = (l * (one + s)) >> h2r_pkg::FRAC_BITS;
            else
                q = l + s - ((l * s) >> h2r_pkg::FRAC_BITS);
            p = 64'd2 * l - q;
            tr = h3 + one;
            if (tr >= full3)
                tr = tr - full3;
            tb = (h3 >= one) ? h3 - one : h3 + full3 - one;
            r = scale_channel(ramp_value(p, q, tr), 2 * h2r_pkg::FRAC_BITS);
            g = scale_channel(ramp_value(p, q, h3), 2 * h2r_pkg::FRAC_BITS);
            b = scale_channel(ramp_value(p, q, tb), 2 * h2r_pkg::FRAC_BITS);
        end
        return {r[7:0], g[7:0], b[7:0]};
    endfunction

    function void note_hsl(
        logic [h2r_pkg::HUE_W-1:0]  hue,
        logic [h2r_pkg::FRAC_W-1:0] sat,
        logic [h2r_pkg::FRAC_W-1:0] light
    );
        pending_colors.push_back(predict_color(hue, sat, light));
    endfunction

    function void check_rgb(logic [h2r_pkg::COLOR_W-1:0] color);
        logic [h2r_pkg::COLOR_W-1:0] wanted;
        if (pending_colors.size() == 0)
        begin
            $error("packed_color: expected no transaction, actual %06h", color);
            error_count++;
        end
        else
        begin
            wanted = pending_colors.pop_front();
            if (color !== wanted)
            begin
                $error("packed_color: expected %06h, actual %06h", wanted, color);
                error_count++;
            end
        end
    endfunction
endclass

module tb_hsl_to_rgb_converter;
    import h2r_pkg::*;

    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned HOLDOFF_CYCLES = 300;

    logic clk;
    logic rst_n;
    bit idling_on;
    bit holdoff_req;
    int unsigned quiet_cycles;

    h2r_hsl_if hsl ();
    h2r_rgb_if rgb ();

    rgb_expectations colors = new();

    hsl_to_rgb_converter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hsl   (hsl),
        .rgb   (rgb)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Every task below starts and ends just after a rising edge.
    task automatic send_hsl(
        logic [HUE_W-1:0]  hue,
        logic [FRAC_W-1:0] sat,
        logic [FRAC_W-1:0] light
    );
        if (idling_on)
        begin
            while ($urandom_range(99) < 26)
            begin
                @(negedge clk);
                hsl.valid <= 1'b0;
                @(posedge clk);
            end
        end
        @(negedge clk);
        hsl.valid      <= 1'b1;
        hsl.hue        <= hue;
        hsl.saturation <= sat;
        hsl.lightness  <= light;
        @(posedge clk);
        while (!hsl.ready)
            @(posedge clk);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        hsl.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_for_drain();
        while (colors.pending_colors.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [FRAC_W-1:0] random_fraction();
        case ($urandom_range(9))
            0: return '0;
            1: return ONE_F;
            2: return FRAC_W'($urandom_range(131071, 65537));
            default: return FRAC_W'($urandom_range(65536));
        endcase
    endfunction

    task automatic send_random(int unsigned count);
        repeat (count)
            send_hsl(HUE_W'($urandom_range(65535)), random_fraction(), random_fraction());
    endtask

    initial
    begin
        int unsigned hold_count;
        hold_count = 0;
        rgb.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_req)
            begin
                rgb.ready <= 1'b0;
                hold_count++;
                if (hold_count == HOLDOFF_CYCLES)
                begin
                    hold_count = 0;
                    holdoff_req = 1'b0;
                end
            end
            else if (idling_on)
                rgb.ready <= ($urandom_range(99) >= 26);
            else
                rgb.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && hsl.valid && hsl.ready)
            colors.note_hsl(hsl.hue, hsl.saturation, hsl.lightness);
        if (rst_n && rgb.valid && rgb.ready)
            colors.check_rgb(rgb.packed_color);
        if ((hsl.valid && hsl.ready) || (rgb.valid && rgb.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        idling_on = 1'b1;
        holdoff_req = 1'b0;
        quiet_cycles = 0;
        hsl.valid = 1'b0;
        hsl.hue = '0;
        hsl.saturation = '0;
        hsl.lightness = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Gray levels, including lightness above one.
        send_hsl(16'h0000, 17'h00000, 17'h00000);
        send_hsl(16'h0000, 17'h00000, 17'h10000);
        send_hsl(16'h1234, 17'h00000, 17'h1FFFF);
        send_hsl(16'h0000, 17'h00000, 17'h08000);
        // Full saturation around the hue circle, on both sides of each sixth but the half, which is sent exactly.
        send_hsl(16'd0,     17'h10000, 17'h08000);
        send_hsl(16'd10922, 17'h10000, 17'h08000);
        send_hsl(16'd10923, 17'h10000, 17'h08000);
        send_hsl(16'd21845, 17'h10000, 17'h08000);
        send_hsl(16'd21846, 17'h10000, 17'h08000);
        send_hsl(16'd32768, 17'h10000, 17'h08000);
        send_hsl(16'd43690, 17'h10000, 17'h08000);
        send_hsl(16'd43691, 17'h10000, 17'h08000);
        send_hsl(16'd54613, 17'h10000, 17'h08000);
        send_hsl(16'd54614, 17'h10000, 17'h08000);
        send_hsl(16'hFFFF,  17'h1FFFF, 17'h07FFF);
        // White, black, the smallest nonzero inputs and values near and above one.
        send_hsl(16'h5555, 17'h10000, 17'h10000);
        send_hsl(16'hAAAA, 17'h10000, 17'h00000);
        send_hsl(16'h8000, 17'h00001, 17'h00001);
        send_hsl(16'h4000, 17'h10001, 17'h10000);
        send_hsl(16'h2000, 17'h0FFFF, 17'h0FFFF);
        send_hsl(16'hC000, 17'h08000, 17'h04000);
        send_hsl(16'h0001, 17'h1FFFF, 17'h1FFFF);

        send_random(350);

        idling_on = 1'b0;
        send_random(300);
        idling_on = 1'b1;

        // The output stalls for a long stretch while transactions keep coming.
        holdoff_req = 1'b1;
        send_random(150);

        stop_sending();
        wait_for_drain();

        send_random(400);

        stop_sending();
        wait_for_drain();
        repeat (20) @(posedge clk);
        if (colors.error_count == 0 && colors.pending_colors.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

`default_nettype wire
